// ----- rtl/dqd_pkg.sv -----
// Shared widths, codes and types of the dual quadrature decoder with speed output.
package dqd_pkg;

    localparam int COUNT_W  = 32;
    localparam int TIME_W   = 32;
    localparam int CIRC_W   = 16;
    localparam int RES_W    = 16;
    localparam int CFG_W    = 16;
    localparam int MS_W     = 10;
    localparam int MS_PER_S = 1000;
    localparam int SCALE_W  = CIRC_W + MS_W;
    localparam int NUM_W    = SCALE_W + COUNT_W;
    localparam int DEN_W    = TIME_W + RES_W;

    localparam logic [CIRC_W-1:0] CIRC_RESET = CIRC_W'(200);
    localparam logic [RES_W-1:0]  RES_RESET  = RES_W'(20);

    // request kinds
    localparam logic [1:0] KIND_LEFT  = 2'd0;
    localparam logic [1:0] KIND_RIGHT = 2'd1;
    localparam logic [1:0] KIND_SPEED = 2'd2;

    // configuration register indexes
    localparam logic REG_CIRC = 1'b0;
    localparam logic REG_RES  = 1'b1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SETUP,
        S_MUL,
        S_DIV,
        S_DONE
    } t_state;

endpackage

// ----- rtl/dqd_if.sv -----
// Request and result channel interfaces.
interface dqd_in_if;
    import dqd_pkg::*;
    logic              valid;
    logic              ready;
    logic [1:0]        kind;
    logic              pin_a;
    logic              pin_b;
    logic [TIME_W-1:0] now_ms;

    modport source (output valid, kind, pin_a, pin_b, now_ms, input ready);
    modport sink   (input valid, kind, pin_a, pin_b, now_ms, output ready);
endinterface

interface dqd_out_if;
    import dqd_pkg::*;
    logic                      valid;
    logic                      ready;
    logic signed [COUNT_W-1:0] speed_left;
    logic signed [COUNT_W-1:0] speed_right;

    modport source (output valid, speed_left, speed_right, input ready);
    modport sink   (input valid, speed_left, speed_right, output ready);
endinterface

// ----- rtl/dqd_decoder.sv -----
// Quadrature phase tracker and pulse counter for one wheel.
module dqd_decoder
    import dqd_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_sample_en,
    input  logic [1:0]         i_sample,
    input  logic               i_clear,
    output logic [COUNT_W-1:0] o_count
);

    logic [1:0]         r_phase, n_phase;
    logic [COUNT_W-1:0] r_count, n_count;

    // Gray sequence 0-1-3-2-0
    function automatic logic [1:0] f_next_fwd(input logic [1:0] p);
        logic [1:0] q;
        unique case (p)
            2'd0: q = 2'd1;
            2'd1: q = 2'd3;
            2'd3: q = 2'd2;
            default: q = 2'd0;
        endcase
        return q;
    endfunction

    function automatic logic [1:0] f_next_rev(input logic [1:0] p);
        logic [1:0] q;
        unique case (p)
            2'd0: q = 2'd2;
            2'd2: q = 2'd3;
            2'd3: q = 2'd1;
            default: q = 2'd0;
        endcase
        return q;
    endfunction

    always_comb begin
        n_phase = r_phase;
        n_count = r_count;
        if (i_clear) begin
            n_count = '0;
        end else if (i_sample_en) begin
            n_phase = i_sample;
            if (i_sample == f_next_fwd(r_phase)) begin
                n_count = r_count + COUNT_W'(1);
            end else if (i_sample == f_next_rev(r_phase)) begin
                n_count = r_count - COUNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= '0;
            r_count <= '0;
        end else begin
            r_phase <= n_phase;
            r_count <= n_count;
        end
    end

    assign o_count = r_count;

endmodule

// ----- rtl/dqd_mul.sv -----
// Bit-serial shift-add multiplier, one multiplier bit per cycle.
module dqd_mul
    import dqd_pkg::*;
#(
    parameter int A_W = CIRC_W,
    parameter int B_W = MS_W
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic [A_W-1:0]     i_a,
    input  logic [B_W-1:0]     i_b,
    output logic               o_busy,
    output logic [A_W+B_W-1:0] o_prod
);

    localparam int P_W   = A_W + B_W;
    localparam int CNT_W = $clog2(B_W + 1);

    logic [A_W-1:0]   r_a;
    logic [P_W-1:0]   r_prod;
    logic [CNT_W-1:0] r_cnt;
    logic             r_busy;
    logic [A_W:0]     w_sum;

    // upper A_W bits accumulate, lower B_W bits hold the multiplier bits still to go
    assign w_sum = {1'b0, r_prod[P_W-1:B_W]} + (r_prod[0] ? {1'b0, r_a} : '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= CNT_W'(B_W);
        end else if (r_busy) begin
            r_busy <= (r_cnt != CNT_W'(1));
            r_cnt  <= r_cnt - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_a    <= i_a;
            r_prod <= {{A_W{1'b0}}, i_b};
        end else if (r_busy) begin
            r_prod <= {w_sum, r_prod[B_W-1:1]};
        end
    end

    assign o_busy = r_busy;
    assign o_prod = r_prod;

endmodule

// ----- rtl/dqd_div.sv -----
// Restoring divider, one quotient bit per cycle.
module dqd_div
    import dqd_pkg::*;
#(
    parameter int N_W = NUM_W,
    parameter int D_W = DEN_W
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_start,
    input  logic [N_W-1:0] i_num,
    input  logic [D_W-1:0] i_den,
    output logic           o_busy,
    output logic [N_W-1:0] o_quo
);

    localparam int CNT_W = $clog2(N_W + 1);

    logic [D_W-1:0]   r_rem;
    logic [D_W-1:0]   r_den;
    logic [N_W-1:0]   r_quo;
    logic [CNT_W-1:0] r_cnt;
    logic             r_busy;
    logic [D_W:0]     w_shift;
    logic [D_W:0]     w_diff;
    logic             w_ge;

    // remainder stays below the divisor, so the shifted value is below twice it
    assign w_shift = {r_rem, r_quo[N_W-1]};
    assign w_diff  = w_shift - {1'b0, r_den};
    assign w_ge    = !w_diff[D_W];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= CNT_W'(N_W);
        end else if (r_busy) begin
            r_busy <= (r_cnt != CNT_W'(1));
            r_cnt  <= r_cnt - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_den <= i_den;
            r_quo <= i_num;
        end else if (r_busy) begin
            r_rem <= w_ge ? w_diff[D_W-1:0] : w_shift[D_W-1:0];
            r_quo <= {r_quo[N_W-2:0], w_ge};
        end
    end

    assign o_busy = r_busy;
    assign o_quo  = r_quo;

endmodule

// ----- rtl/dual_quadrature_decoder_speed.sv -----
// Top level: two quadrature decoders and a serial speed calculator.
//
//  channel   dir  handshake          payload
//  i_in      in   valid/ready        kind, pin_a, pin_b, now_ms
//  o_out     out  valid/ready        speed_left, speed_right
//  i_cfg_*   in   write enable only  idx, data (circumference, resolution)
//
// Pin samples and ignored kinds are taken while idle and leave the block idle.
// A speed request with elapsed time holds the input while it is computed: first
// the circumference and divisor products, then per wheel the bit-serial
// numerator multiply and the bit-serial 58-bit divide, then the load of the
// output register; a result still waiting there holds the input until taken.
// Synchronous active-low reset; counts, phases and time go to zero.
// A result waits in the output register; pin samples and the next request
// are taken while it is held.
module dual_quadrature_decoder_speed
    import dqd_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    dqd_in_if.sink           i_in,
    dqd_out_if.source        o_out,
    input  logic             i_cfg_we,
    input  logic             i_cfg_idx,
    input  logic [CFG_W-1:0] i_cfg_data
);

    t_state r_state, n_state;

    logic [CIRC_W-1:0]  r_circ;
    logic [RES_W-1:0]   r_res;
    logic [TIME_W-1:0]  r_last_ms;
    logic [COUNT_W-1:0] r_mag_l, r_mag_r;
    logic               r_neg_l, r_neg_r;
    logic               r_sel;
    logic [COUNT_W-1:0] r_spd_l;
    logic               r_out_valid;
    logic [COUNT_W-1:0] r_out_l, r_out_r;

    logic               w_acc;
    logic [TIME_W-1:0]  w_elapsed;
    logic               w_go;
    logic               w_start_num, w_start_div, w_store_l, w_load_out;
    logic [COUNT_W-1:0] w_count_l, w_count_r;
    logic [RES_W-1:0]   w_res;
    logic [SCALE_W-1:0] w_scale;
    logic [DEN_W-1:0]   w_den;
    logic [NUM_W-1:0]   w_num, w_quo;
    logic               w_scale_busy, w_den_busy, w_num_busy, w_div_busy;
    logic [COUNT_W-1:0] w_sat;

    assign w_acc     = i_in.valid && i_in.ready;
    assign w_elapsed = i_in.now_ms - r_last_ms;
    assign w_go      = w_acc && (i_in.kind == KIND_SPEED) && (w_elapsed != '0);
    assign w_res     = (r_res == '0) ? RES_W'(1) : r_res;

    function automatic logic [COUNT_W-1:0] f_abs(input logic [COUNT_W-1:0] c);
        return c[COUNT_W-1] ? (~c + COUNT_W'(1)) : c;
    endfunction

    // truncated quotient to signed 32-bit with saturation
    function automatic logic [COUNT_W-1:0] f_sat(input logic [NUM_W-1:0] q,
                                                 input logic neg);
        logic [COUNT_W-1:0] r;
        if (neg) begin
            if ((|q[NUM_W-1:COUNT_W]) || (q[COUNT_W-1] && (|q[COUNT_W-2:0]))) begin
                r = {1'b1, {(COUNT_W-1){1'b0}}};
            end else begin
                r = ~q[COUNT_W-1:0] + COUNT_W'(1);
            end
        end else begin
            if (|q[NUM_W-1:COUNT_W-1]) begin
                r = {1'b0, {(COUNT_W-1){1'b1}}};
            end else begin
                r = q[COUNT_W-1:0];
            end
        end
        return r;
    endfunction

    assign w_sat = f_sat(w_quo, r_sel ? r_neg_r : r_neg_l);

    dqd_decoder u_dec_l (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_sample_en (w_acc && (i_in.kind == KIND_LEFT)),
        .i_sample    ({i_in.pin_b, i_in.pin_a}),
        .i_clear     (w_go),
        .o_count     (w_count_l)
    );

    dqd_decoder u_dec_r (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_sample_en (w_acc && (i_in.kind == KIND_RIGHT)),
        .i_sample    ({i_in.pin_b, i_in.pin_a}),
        .i_clear     (w_go),
        .o_count     (w_count_r)
    );

    // circumference * 1000
    dqd_mul #(.A_W(CIRC_W), .B_W(MS_W)) u_mul_scale (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_go),
        .i_a     (r_circ),
        .i_b     (MS_W'(MS_PER_S)),
        .o_busy  (w_scale_busy),
        .o_prod  (w_scale)
    );

    // resolution * elapsed
    dqd_mul #(.A_W(TIME_W), .B_W(RES_W)) u_mul_den (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_go),
        .i_a     (w_elapsed),
        .i_b     (w_res),
        .o_busy  (w_den_busy),
        .o_prod  (w_den)
    );

    dqd_mul #(.A_W(SCALE_W), .B_W(COUNT_W)) u_mul_num (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_start_num),
        .i_a     (w_scale),
        .i_b     ((r_state == S_SETUP) ? r_mag_l : r_mag_r),
        .o_busy  (w_num_busy),
        .o_prod  (w_num)
    );

    dqd_div #(.N_W(NUM_W), .D_W(DEN_W)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_start_div),
        .i_num   (w_num),
        .i_den   (w_den),
        .o_busy  (w_div_busy),
        .o_quo   (w_quo)
    );

    always_comb begin
        n_state     = r_state;
        w_start_num = 1'b0;
        w_start_div = 1'b0;
        w_store_l   = 1'b0;
        w_load_out  = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (w_go) n_state = S_SETUP;
            end
            S_SETUP: begin
                if (!w_scale_busy && !w_den_busy) begin
                    w_start_num = 1'b1;
                    n_state     = S_MUL;
                end
            end
            S_MUL: begin
                if (!w_num_busy) begin
                    w_start_div = 1'b1;
                    n_state     = S_DIV;
                end
            end
            S_DIV: begin
                if (!w_div_busy) begin
                    if (!r_sel) begin
                        w_store_l   = 1'b1;
                        w_start_num = 1'b1;
                        n_state     = S_MUL;
                    end else begin
                        n_state = S_DONE;
                    end
                end
            end
            S_DONE: begin
                if (!r_out_valid || o_out.ready) begin
                    w_load_out = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_circ      <= CIRC_RESET;
            r_res       <= RES_RESET;
            r_last_ms   <= '0;
            r_sel       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we && (i_cfg_idx == REG_CIRC)) r_circ <= i_cfg_data;
            if (i_cfg_we && (i_cfg_idx == REG_RES))  r_res  <= i_cfg_data;
            if (w_go) r_last_ms <= i_in.now_ms;
            if (w_store_l) begin
                r_sel <= 1'b1;
            end else if (w_load_out) begin
                r_sel <= 1'b0;
            end
            if (w_load_out) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_go) begin
            r_mag_l <= f_abs(w_count_l);
            r_mag_r <= f_abs(w_count_r);
            r_neg_l <= w_count_l[COUNT_W-1];
            r_neg_r <= w_count_r[COUNT_W-1];
        end
        if (w_store_l) r_spd_l <= w_sat;
        if (w_load_out) begin
            r_out_l <= r_spd_l;
            r_out_r <= w_sat;
        end
    end

    assign i_in.ready        = (r_state == S_IDLE);
    assign o_out.valid       = r_out_valid;
    assign o_out.speed_left  = r_out_l;
    assign o_out.speed_right = r_out_r;

    // counts are cleared on a started request and frozen until it finishes
    a_counts_frozen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> (w_count_l == '0 && w_count_r == '0))
        else $error("wheel count moved during a speed calculation");

    a_go_setup: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_go |=> (r_state == S_SETUP))
        else $error("speed request did not start the calculation");

    a_result_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> ($past(r_state) == S_DONE))
        else $error("result raised outside the completion step");

    a_sel_scope: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sel |-> (r_state == S_MUL || r_state == S_DIV || r_state == S_DONE))
        else $error("right-wheel select left set while idle");

endmodule

// ----- bench/dqd_speed_checker.sv -----
// Checker for the dual quadrature decoder: tracks decoder state, predicts speed results, compares.
`timescale 1ns / 1ps

module dqd_speed_checker
    import dqd_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    dqd_in_if                i_req,
    dqd_out_if               i_res,
    input  logic             i_cfg_we,
    input  logic             i_cfg_idx,
    input  logic [CFG_W-1:0] i_cfg_data,
    output int               o_pending,
    output int               o_fail_count
);

    typedef struct packed {
        logic signed [COUNT_W-1:0] left_mm_s;
        logic signed [COUNT_W-1:0] right_mm_s;
    } t_wheel_speeds;

    t_wheel_speeds      pending_speeds[$];
    t_wheel_speeds      want;

    logic [CIRC_W-1:0]  circ_mm;
    logic [RES_W-1:0]   counts_per_rev;
    logic [1:0]         left_phase;
    logic [1:0]         right_phase;
    logic [COUNT_W-1:0] left_count;
    logic [COUNT_W-1:0] right_count;
    logic [TIME_W-1:0]  last_ms;
    logic [TIME_W-1:0]  elapsed_ms;

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
    end

    // Count after moving from phase cur to phase nxt; jumps across two steps do not count.
    function automatic logic [COUNT_W-1:0] count_after(logic [1:0] cur, logic [1:0] nxt,
                                                       logic [COUNT_W-1:0] count);
        case ({cur, nxt})
            4'b00_01, 4'b01_11, 4'b11_10, 4'b10_00: return count + 1;
            4'b01_00, 4'b11_01, 4'b10_11, 4'b00_10: return count - 1;
            default: return count;
        endcase
    endfunction

    // mm/s from a signed count over an elapsed time, truncated toward zero and saturated.
    function automatic logic signed [COUNT_W-1:0] speed_mm_s(logic [COUNT_W-1:0] count,
                                                             logic [TIME_W-1:0] elapsed);
        logic [63:0]      mag;
        logic [63:0]      num;
        logic [63:0]      den;
        logic [63:0]      quo;
        logic [RES_W-1:0] res;
        mag = count[COUNT_W-1] ? {32'd0, -count} : {32'd0, count};
        res = (counts_per_rev == '0) ? RES_W'(1) : counts_per_rev;
        num = mag * {48'd0, circ_mm} * 64'd1000;
        den = {48'd0, res} * {32'd0, elapsed};
        quo = num / den;
        if (count[COUNT_W-1]) begin
            if (quo > 64'h8000_0000)
                quo = 64'h8000_0000;
            return -quo[31:0];
        end
        if (quo > 64'h7FFF_FFFF)
            quo = 64'h7FFF_FFFF;
        return quo[31:0];
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            circ_mm        = CIRC_RESET;
            counts_per_rev = RES_RESET;
            left_phase     = 2'd0;
            right_phase    = 2'd0;
            left_count     = '0;
            right_count    = '0;
            last_ms        = '0;
            pending_speeds.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_CIRC: circ_mm        = i_cfg_data;
                    REG_RES:  counts_per_rev = i_cfg_data;
                    default: ;
                endcase
            end

            // results first: one arriving now belongs to an earlier request
            if (i_res.valid && i_res.ready) begin
                if (pending_speeds.size() == 0) begin
                    o_fail_count++;
                    $display("%0t: unexpected result left %0d right %0d", $time,
                             i_res.speed_left, i_res.speed_right);
                end else begin
                    want = pending_speeds.pop_front();
                    if (want.left_mm_s !== i_res.speed_left) begin
                        o_fail_count++;
                        $display("%0t: speed_left expected %0d got %0d", $time,
                                 want.left_mm_s, i_res.speed_left);
                    end
                    if (want.right_mm_s !== i_res.speed_right) begin
                        o_fail_count++;
                        $display("%0t: speed_right expected %0d got %0d", $time,
                                 want.right_mm_s, i_res.speed_right);
                    end
                end
            end

            if (i_req.valid && i_req.ready) begin
                case (i_req.kind)
                    KIND_LEFT: begin
                        left_count = count_after(left_phase, {i_req.pin_b, i_req.pin_a},
                                                 left_count);
                        left_phase = {i_req.pin_b, i_req.pin_a};
                    end
                    KIND_RIGHT: begin
                        right_count = count_after(right_phase, {i_req.pin_b, i_req.pin_a},
                                                  right_count);
                        right_phase = {i_req.pin_b, i_req.pin_a};
                    end
                    KIND_SPEED: begin
                        elapsed_ms = i_req.now_ms - last_ms;
                        if (elapsed_ms != '0) begin
                            want.left_mm_s  = speed_mm_s(left_count, elapsed_ms);
                            want.right_mm_s = speed_mm_s(right_count, elapsed_ms);
                            pending_speeds.push_back(want);
                            left_count  = '0;
                            right_count = '0;
                            last_ms     = i_req.now_ms;
                        end
                    end
                    default: ;
                endcase
            end
        end
        o_pending = pending_speeds.size();
    end

endmodule

// ----- bench/dual_quadrature_decoder_speed_tb.sv -----
// Testbench top for the dual quadrature decoder: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module dual_quadrature_decoder_speed_tb;
    import dqd_pkg::*;

    localparam logic [1:0] KIND_UNUSED  = 2'd3;
    localparam int         SETTLE_TICKS = 260;

    logic             i_clk;
    logic             i_rst_n;
    logic             i_cfg_we;
    logic             i_cfg_idx;
    logic [CFG_W-1:0] i_cfg_data;
    int               pending;
    int               fail_count;

    logic             no_idle;
    logic [1:0]       side_phase[2];
    logic             side_fwd[2];
    logic [TIME_W-1:0] last_ms;

    dqd_in_if  req_if();
    dqd_out_if res_if();

    dual_quadrature_decoder_speed dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (req_if),
        .o_out      (res_if),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    dqd_speed_checker checker_i (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req        (req_if),
        .i_res        (res_if),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .o_pending    (pending),
        .o_fail_count (fail_count)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        #20_000_000;
        $display("Mismatches found");
        $finish;
    end

    // result side: random stall before each result, none while no_idle is set
    initial begin
        int stall;
        res_if.ready = 1'b0;
        @(negedge i_clk);
        forever begin
            stall = no_idle ? 0 : $urandom_range(0, 9);
            if (stall != 0) begin
                res_if.ready <= 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            res_if.ready <= 1'b1;
            @(posedge i_clk);
            while (!res_if.valid) @(posedge i_clk);
            @(negedge i_clk);
        end
    end

    function automatic logic [1:0] gray_next(logic [1:0] p, logic fwd);
        case (p)
            2'd0:    return fwd ? 2'd1 : 2'd2;
            2'd1:    return fwd ? 2'd3 : 2'd0;
            2'd3:    return fwd ? 2'd2 : 2'd1;
            default: return fwd ? 2'd0 : 2'd3;
        endcase
    endfunction

    // Starts and ends at a falling edge; valid stays high across back-to-back requests.
    task automatic push_request(input logic [1:0] kind, input logic a, input logic b,
                                input logic [TIME_W-1:0] now);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 9);
        if (gap != 0) begin
            req_if.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        req_if.valid  <= 1'b1;
        req_if.kind   <= kind;
        req_if.pin_a  <= a;
        req_if.pin_b  <= b;
        req_if.now_ms <= now;
        @(posedge i_clk);
        while (!req_if.ready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic drive_sample(input int side, input logic [1:0] p);
        push_request(side ? KIND_RIGHT : KIND_LEFT, p[0], p[1], $urandom());
        side_phase[side] = p;
    endtask

    task automatic request_speed(input logic [TIME_W-1:0] now);
        push_request(KIND_SPEED, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), now);
        last_ms = now;
    endtask

    task automatic walk(input int side, input logic fwd, input int steps);
        repeat (steps) drive_sample(side, gray_next(side_phase[side], fwd));
    endtask

    // drain all outstanding results, then let any request with no result finish
    task automatic settle();
        req_if.valid <= 1'b0;
        @(negedge i_clk);
        while (pending != 0) @(negedge i_clk);
        repeat (SETTLE_TICKS) @(negedge i_clk);
    endtask

    task automatic reg_write(input logic idx, input logic [CFG_W-1:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic random_item();
        int         sel;
        int         side;
        int         d;
        logic [1:0] p;
        sel  = $urandom_range(0, 99);
        side = $urandom_range(0, 1);
        if (sel < 75) begin
            // runs in one direction so counts build up
            if ($urandom_range(0, 19) == 0)
                side_fwd[side] = !side_fwd[side];
            drive_sample(side, gray_next(side_phase[side], side_fwd[side]));
        end else if (sel < 80) begin
            drive_sample(side, side_phase[side] ^ 2'b11);
        end else if (sel < 83) begin
            drive_sample(side, side_phase[side]);
        end else if (sel < 85) begin
            p = 2'($urandom_range(0, 3));
            push_request(KIND_UNUSED, p[0], p[1], $urandom());
        end else begin
            d = $urandom_range(0, 19);
            if (d == 0)
                request_speed(last_ms);
            else if (d == 1)
                request_speed($urandom());
            else
                request_speed(last_ms + $urandom_range(1, 200));
        end
    endtask

    initial begin
        no_idle       = 1'b0;
        side_phase[0] = 2'd0;
        side_phase[1] = 2'd0;
        side_fwd[0]   = 1'b1;
        side_fwd[1]   = 1'b0;
        last_ms       = '0;
        i_rst_n       = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_idx     = REG_CIRC;
        i_cfg_data    = '0;
        req_if.valid  = 1'b0;
        req_if.kind   = KIND_LEFT;
        req_if.pin_a  = 1'b0;
        req_if.pin_b  = 1'b0;
        req_if.now_ms = '0;
        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed: full forward cycle on the left, reverse on the right
        drive_sample(0, 2'd1);
        drive_sample(0, 2'd3);
        drive_sample(0, 2'd2);
        drive_sample(0, 2'd0);
        drive_sample(0, 2'd3);          // jump across two steps
        drive_sample(1, 2'd2);
        drive_sample(1, 2'd3);
        drive_sample(1, 2'd3);          // same phase again
        drive_sample(1, 2'd1);
        drive_sample(1, 2'd2);          // jump across two steps
        push_request(KIND_UNUSED, 1'b1, 1'b1, '1);
        request_speed('0);              // no time passed
        request_speed(32'd1000);
        request_speed(32'hFFFF_FFFF);
        drive_sample(0, 2'd2);
        request_speed(32'd4);           // clock wrapped
        settle();

        for (int ph = 0; ph < 6; ph++) begin
            if (ph != 0) begin
                settle();
                case (ph)
                    1: begin
                        reg_write(REG_CIRC, 16'hFFFF);
                        reg_write(REG_RES, 16'd1);
                    end
                    2: begin
                        reg_write(REG_CIRC, 16'd1);
                        reg_write(REG_RES, 16'hFFFF);
                    end
                    3: begin
                        reg_write(REG_CIRC, 16'd0);
                        reg_write(REG_RES, 16'd0);
                    end
                    default: begin
                        reg_write(REG_CIRC, 16'($urandom_range(1, 65535)));
                        reg_write(REG_RES, 16'($urandom_range(1, 65535)));
                    end
                endcase
            end
            if (ph == 1) begin
                // large counts over one millisecond saturate both ways
                walk(0, 1'b1, 40);
                walk(1, 1'b0, 40);
                request_speed(last_ms + 1);
            end
            repeat (4) begin
                no_idle = ($urandom_range(0, 3) == 0);
                repeat (25) random_item();
            end
            no_idle = 1'b0;
        end

        settle();
        if (fail_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
